/* sv/xor_sprite_row_plotter_macros.svh */
// Assertion macros for the sprite row plotter.
`ifndef XOR_SPRITE_ROW_PLOTTER_MACROS_SVH
`define XOR_SPRITE_ROW_PLOTTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define XSRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("xsrp: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define XSRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("xsrp: next-cycle check failed");

`else

`define XSRP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define XSRP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* sv/xsrp_pkg.sv */
`timescale 1ns / 1ps

package xsrp_pkg;

	// Command field widths
	localparam int COORD_W   = 16;
	localparam int PATTERN_W = 8;

	// Default screen geometry
	localparam int SCREEN_COLS_DEF = 64;
	localparam int SCREEN_ROWS_DEF = 32;

	// Front-to-back command queue
	localparam int QUEUE_DEPTH = 4;

	// Fixed-point reciprocal width used for modulo by a constant
	localparam int RECIP_W = 32;

	typedef enum logic [1:0] {
		MODE_DRAW  = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_SET   = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef struct packed {
		logic pixel;
		logic collision;
	} result_t;

endpackage

/* sv/xsrp_wrap.sv */
`timescale 1ns / 1ps

// Three-stage signed modulo by a constant, result always in 0..MODULUS-1.
// Negative v folds as MODULUS-1 - ((~v) mod MODULUS).
module xsrp_wrap #(
	parameter int MODULUS = xsrp_pkg::SCREEN_COLS_DEF,
	parameter int OUT_W   = 6
) (
	input  logic                              clk,
	input  logic signed [xsrp_pkg::COORD_W-1:0] value,
	output logic [OUT_W-1:0]                  coord
);

	localparam int UW    = xsrp_pkg::COORD_W - 1;
	localparam int RW    = xsrp_pkg::RECIP_W;
	localparam int REM_W = (MODULUS > 1) ? $clog2(2 * MODULUS) : 1;
	localparam logic [RW-1:0] RECIP = RW'(64'hFFFF_FFFF / MODULUS);

	logic [UW-1:0]    mag;
	logic [UW+RW-1:0] prod_s1;
	logic [UW-1:0]    mag_s1;
	logic             neg_s1;
	logic [UW-1:0]    quot;
	logic [UW-1:0]    back_prod;
	logic [REM_W-1:0] rem_s2;
	logic             neg_s2;
	logic [REM_W-1:0] rem_fix;
	logic [OUT_W-1:0] coord_s3;

	// Fold sign: magnitude of v or of ~v
	assign mag = value[UW] ? ~value[UW-1:0] : value[UW-1:0];

	// Stage 1: reciprocal product
	always_ff @(posedge clk) begin
		prod_s1 <= (UW+RW)'(mag) * (UW+RW)'(RECIP);
		mag_s1  <= mag;
		neg_s1  <= value[UW];
	end

	// Stage 2: raw remainder, at most one modulus too large
	assign quot      = prod_s1[UW+RW-1 -: UW];
	assign back_prod = UW'(quot * MODULUS);

	always_ff @(posedge clk) begin
		rem_s2 <= REM_W'(mag_s1 - back_prod);
		neg_s2 <= neg_s1;
	end

	// Stage 3: correction and sign unfold
	assign rem_fix = (rem_s2 >= REM_W'(MODULUS)) ? rem_s2 - REM_W'(MODULUS) : rem_s2;

	always_ff @(posedge clk) begin
		if (neg_s2) begin
			coord_s3 <= OUT_W'(REM_W'(MODULUS - 1) - rem_fix);
		end else begin
			coord_s3 <= OUT_W'(rem_fix);
		end
	end

	assign coord = coord_s3;

endmodule

/* sv/xsrp_front.sv */
`timescale 1ns / 1ps

// Front end: accepts commands, wraps coordinates, builds the row mask and
// pushes one classified command per item into the queue.
module xsrp_front #(
	parameter int SCREEN_COLS = xsrp_pkg::SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = xsrp_pkg::SCREEN_ROWS_DEF,
	parameter int ROW_W       = 5,
	parameter int ENTRY_W     = 72,
	parameter int CNT_W       = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  xsrp_pkg::mode_t                      mode,
	input  logic signed [xsrp_pkg::COORD_W-1:0]  column,
	input  logic signed [xsrp_pkg::COORD_W-1:0]  row,
	input  logic [xsrp_pkg::PATTERN_W-1:0]       pattern,
	input  logic [CNT_W-1:0]                     q_count,
	output logic                                 push,
	output logic [ENTRY_W-1:0]                   push_data,
	output logic [1:0]                           inflight
);

	localparam int COL_W = $clog2(SCREEN_COLS);
	localparam int PW    = xsrp_pkg::PATTERN_W;

	logic                  accept;
	logic                  v_s1, v_s2, v_s3;
	xsrp_pkg::mode_t       mode_s1, mode_s2, mode_s3;
	logic [PW-1:0]         pattern_s1, pattern_s2, pattern_s3;
	logic [COL_W-1:0]      col_s3;
	logic [ROW_W-1:0]      row_s3;
	logic [SCREEN_COLS-1:0] mask;

	// Credit check: queued plus in-flight items never exceed the queue depth
	assign inflight = 2'({1'b0, v_s1} + {1'b0, v_s2} + {1'b0, v_s3});
	assign in_ready = ((CNT_W+1)'(q_count) + (CNT_W+1)'(inflight))
		< (CNT_W+1)'(xsrp_pkg::QUEUE_DEPTH);
	assign accept   = in_valid & in_ready;

	// Coordinate wrap units, aligned with stage 3
	xsrp_wrap #(
		.MODULUS (SCREEN_COLS),
		.OUT_W   (COL_W)
	) u_col_wrap (
		.clk   (clk),
		.value (column),
		.coord (col_s3)
	);

	xsrp_wrap #(
		.MODULUS (SCREEN_ROWS),
		.OUT_W   (ROW_W)
	) u_row_wrap (
		.clk   (clk),
		.value (row),
		.coord (row_s3)
	);

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Command payload alongside the wrap pipeline
	always_ff @(posedge clk) begin
		mode_s1    <= mode;
		pattern_s1 <= pattern;
		mode_s2    <= mode_s1;
		pattern_s2 <= pattern_s1;
		mode_s3    <= mode_s2;
		pattern_s3 <= pattern_s2;
	end

	// Row mask: the pattern's set bits over eight wrapped columns for draw, one column for set and read, none for clear
	always_comb begin
		logic [COL_W:0] ci;
		mask = '0;
		ci   = '0;
		case (mode_s3)
			xsrp_pkg::MODE_DRAW: begin
				for (int i = 0; i < PW; i++) begin
					ci = (COL_W+1)'(col_s3) + (COL_W+1)'(i);
					if (ci >= (COL_W+1)'(SCREEN_COLS)) begin
						ci = ci - (COL_W+1)'(SCREEN_COLS);
					end
					if (pattern_s3[PW-1-i]) begin
						mask[ci[COL_W-1:0]] = 1'b1;
					end
				end
			end
			xsrp_pkg::MODE_SET, xsrp_pkg::MODE_READ: begin
				mask[col_s3] = 1'b1;
			end
			default: begin
				mask = '0;
			end
		endcase
	end

	assign push      = v_s3;
	assign push_data = {mode_s3, row_s3, mask, pattern_s3[0]};

endmodule

/* sv/xsrp_queue.sv */
`timescale 1ns / 1ps

// Short FIFO between front and back ends.
module xsrp_queue #(
	parameter int WIDTH = 72,
	parameter int DEPTH = xsrp_pkg::QUEUE_DEPTH,
	parameter int CNT_W = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic [CNT_W-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data = entries_q[rd_ptr_q];
	assign count    = count_q;

endmodule

/* sv/xsrp_back.sv */
`timescale 1ns / 1ps

// Back end: frame store with per-row valid flags, read-modify-write of one
// row word per draw or set command, and the result register.
module xsrp_back #(
	parameter int SCREEN_COLS = xsrp_pkg::SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = xsrp_pkg::SCREEN_ROWS_DEF,
	parameter int ROW_W       = 5,
	parameter int ENTRY_W     = 72,
	parameter int CNT_W       = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [ENTRY_W-1:0]   q_data,
	input  logic [CNT_W-1:0]     q_count,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output xsrp_pkg::result_t    out_result
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t                  state_q;
	logic [SCREEN_ROWS-1:0]  row_valid_q;
	logic                    out_valid_q;
	xsrp_pkg::result_t       out_res_q;

	logic [SCREEN_COLS-1:0]  frame_mem_q [SCREEN_ROWS];
	logic [SCREEN_COLS-1:0]  rd_q;

	xsrp_pkg::mode_t         mode_q;
	logic [ROW_W-1:0]        row_q;
	logic [SCREEN_COLS-1:0]  mask_q;
	logic                    setv_q;

	xsrp_pkg::mode_t         e_mode;
	logic [ROW_W-1:0]        e_row;
	logic [SCREEN_COLS-1:0]  e_mask;
	logic                    e_setv;

	logic                    slot_free;
	logic                    is_clear;
	logic [SCREEN_COLS-1:0]  row_word;
	logic [SCREEN_COLS-1:0]  new_word;
	logic                    hit;
	logic                    wr_en;
	xsrp_pkg::result_t       exec_res;

	// Queue entry fields
	assign e_mode = xsrp_pkg::mode_t'(q_data[ENTRY_W-1 -: 2]);
	assign e_row  = q_data[ENTRY_W-3 -: ROW_W];
	assign e_mask = q_data[SCREEN_COLS:1];
	assign e_setv = q_data[0];

	assign slot_free = !out_valid_q || out_ready;
	assign pop       = (state_q == ST_IDLE) && (q_count != '0) && slot_free;
	assign is_clear  = (e_mode == xsrp_pkg::MODE_CLEAR);

	// Row update: rows never written since reset or clear read as off
	assign row_word = row_valid_q[row_q] ? rd_q : '0;
	assign hit      = |(row_word & mask_q);

	always_comb begin
		new_word = row_word;
		wr_en    = 1'b0;
		exec_res = '0;
		case (mode_q)
			xsrp_pkg::MODE_DRAW: begin
				new_word           = row_word ^ mask_q;
				wr_en              = 1'b1;
				exec_res.collision = hit;
			end
			xsrp_pkg::MODE_SET: begin
				new_word = setv_q ? (row_word | mask_q) : (row_word & ~mask_q);
				wr_en    = 1'b1;
			end
			xsrp_pkg::MODE_READ: begin
				exec_res.pixel = hit;
			end
			default: begin
				new_word = row_word;
			end
		endcase
	end

	// Sequencer, row valid flags and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a clear popped in the same cycle reloads the slot instead
			if (out_valid_q && out_ready && (state_q == ST_IDLE) && !(pop && is_clear)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (is_clear) begin
							row_valid_q <= '0;
							out_valid_q <= 1'b1;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					if (wr_en) begin
						row_valid_q[row_q] <= 1'b1;
					end
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command registers and result data
	always_ff @(posedge clk) begin
		if (pop) begin
			mode_q <= e_mode;
			row_q  <= e_row;
			mask_q <= e_mask;
			setv_q <= e_setv;
		end
		if (pop && is_clear) begin
			out_res_q <= '0;
		end else if (state_q == ST_EXEC) begin
			out_res_q <= exec_res;
		end
	end

	// Frame store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if ((state_q == ST_EXEC) && wr_en) begin
			frame_mem_q[row_q] <= new_word;
		end
		if (pop) begin
			rd_q <= frame_mem_q[e_row];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_res_q;

endmodule

/* sv/xor_sprite_row_plotter.sv */
`timescale 1ns / 1ps
// A command passes the wrap stages and the queue; draw, set and read then pass the row read
// and the execute state (write-back) before the result register, and the back end pops no
// new command until that is done. A clear resets the row flags and the result when popped.
// Reset: arst_n clears all control state and every row-valid flag, so the
// whole frame reads as off at once; no clearing pass is needed.
`include "xor_sprite_row_plotter_macros.svh"

module xor_sprite_row_plotter #(
	parameter int SCREEN_COLS = xsrp_pkg::SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = xsrp_pkg::SCREEN_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // column[15:0], row[31:16], pattern[39:32]
	input  logic [1:0]  s_axis_tuser,  // mode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // collision[0], pixel[1], zero[7:2]
);

	localparam int ROW_W   = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
	localparam int ENTRY_W = 2 + ROW_W + SCREEN_COLS + 1;
	localparam int CNT_W   = $clog2(xsrp_pkg::QUEUE_DEPTH + 1);
	localparam int CW      = xsrp_pkg::COORD_W;

	logic                 q_push;
	logic [ENTRY_W-1:0]   q_push_data;
	logic                 q_pop;
	logic [ENTRY_W-1:0]   q_pop_data;
	logic [CNT_W-1:0]     q_count;
	logic [1:0]           inflight;
	xsrp_pkg::result_t    result;

	// Front end
	xsrp_front #(
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS),
		.ROW_W       (ROW_W),
		.ENTRY_W     (ENTRY_W),
		.CNT_W       (CNT_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.mode      (xsrp_pkg::mode_t'(s_axis_tuser)),
		.column    (s_axis_tdata[CW-1:0]),
		.row       (s_axis_tdata[2*CW-1:CW]),
		.pattern   (s_axis_tdata[2*CW+xsrp_pkg::PATTERN_W-1:2*CW]),
		.q_count   (q_count),
		.push      (q_push),
		.push_data (q_push_data),
		.inflight  (inflight)
	);

	// Command queue
	xsrp_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (xsrp_pkg::QUEUE_DEPTH),
		.CNT_W (CNT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.count     (q_count)
	);

	// Back end
	xsrp_back #(
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS),
		.ROW_W       (ROW_W),
		.ENTRY_W     (ENTRY_W),
		.CNT_W       (CNT_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_data     (q_pop_data),
		.q_count    (q_count),
		.pop        (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (result)
	);

	assign m_axis_tdata = {6'b0, result.pixel, result.collision};

	// Queue never overflows or underflows, and credits cover all items in flight
	`XSRP_ASSERT_NOW(a_no_overflow, clk, arst_n, q_push && !q_pop, q_count < CNT_W'(xsrp_pkg::QUEUE_DEPTH))
	`XSRP_ASSERT_NOW(a_no_underflow, clk, arst_n, q_pop, q_count != '0)
	`XSRP_ASSERT_NOW(a_credit, clk, arst_n, 1'b1, ((CNT_W+1)'(q_count) + (CNT_W+1)'(inflight)) <= (CNT_W+1)'(xsrp_pkg::QUEUE_DEPTH))
	`XSRP_ASSERT_NEXT(a_accept_enters, clk, arst_n, s_axis_tvalid && s_axis_tready, inflight != 2'd0)

endmodule

/* dv/xor_sprite_row_plotter_test.sv */
`timescale 1ns / 1ps

module xor_sprite_row_plotter_test;
	import xsrp_pkg::*;

	localparam int COLS        = SCREEN_COLS_DEF;
	localparam int ROWS        = SCREEN_ROWS_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 20;
	localparam int RANDOM_CMDS = 550;

	typedef struct {
		mode_t       mode;
		logic [15:0] column;
		logic [15:0] row;
		logic [7:0]  pattern;
	} plot_cmd_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata  = '0;  // column[15:0], row[31:16], pattern[39:32]
	logic [1:0]  s_axis_tuser  = MODE_DRAW;  // mode[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;  // collision[0], pixel[1], zero[7:2]

	// Shadow copy of the frame store
	logic [COLS-1:0] shadow_rows [ROWS];

	plot_cmd_t command_queue [$];
	result_t   expected_flags [$];

	int error_count = 0;
	int send_gap    = 0;
	int send_burst  = 0;
	int recv_gap    = 0;
	int recv_burst  = 0;
	int idle_cycles = 0;

	xor_sprite_row_plotter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Fold a signed coordinate into 0..size-1 (truncating remainder, then fix-up)
	function automatic int wrap_to(int value, int size);
		int rem;
		rem = value % size;
		if (rem < 0) begin
			rem += size;
		end
		return rem;
	endfunction

	// Apply one command to the shadow frame and return the flags it produces
	function automatic result_t plot_command(mode_t mode, int column, int row,
			logic [7:0] pattern);
		result_t res;
		int r;
		int c;
		res = '0;
		r = wrap_to(row, ROWS);
		case (mode)
			MODE_DRAW: begin
				// msb lands on the leftmost column, pixels applied left to right
				for (int i = 0; i < 8; i++) begin
					if (pattern[7 - i]) begin
						c = wrap_to(column + i, COLS);
						if (shadow_rows[r][c]) begin
							res.collision = 1'b1;
						end
						shadow_rows[r][c] = ~shadow_rows[r][c];
					end
				end
			end
			MODE_CLEAR: begin
				foreach (shadow_rows[k]) begin
					shadow_rows[k] = '0;
				end
			end
			MODE_SET: begin
				shadow_rows[r][wrap_to(column, COLS)] = pattern[0];
			end
			default: begin
				res.pixel = shadow_rows[r][wrap_to(column, COLS)];
			end
		endcase
		return res;
	endfunction

	// Idle cycles before the next transaction; occasional back-to-back runs
	function automatic int draw_gap(ref int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 30) == 0) begin
			burst = 20;
		end
		return $urandom_range(0, 10);
	endfunction

	task automatic add_cmd(mode_t mode, int column, int row, int pattern);
		plot_cmd_t cmd;
		cmd.mode    = mode;
		cmd.column  = column[15:0];
		cmd.row     = row[15:0];
		cmd.pattern = pattern[7:0];
		command_queue.push_back(cmd);
	endtask

	// Command driver: predict on each accepted transaction, then load the next one
	always @(posedge clk or negedge arst_n) begin
		plot_cmd_t cmd;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= MODE_DRAW;
			send_gap      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_flags.push_back(plot_command(mode_t'(s_axis_tuser),
					$signed(s_axis_tdata[15:0]), $signed(s_axis_tdata[31:16]),
					s_axis_tdata[39:32]));
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the current command
			end else if (send_gap > 0) begin
				send_gap      <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (command_queue.size() != 0) begin
				cmd = command_queue.pop_front();
				s_axis_tdata  <= {cmd.pattern, cmd.row, cmd.column};
				s_axis_tuser  <= cmd.mode;
				s_axis_tvalid <= 1'b1;
				send_gap      <= draw_gap(send_burst);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result monitor: random backpressure, compare against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		int gap;
		if (!arst_n) begin
			m_axis_tready <= 1'b1;
			recv_gap      <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			if (expected_flags.size() == 0) begin
				if (error_count < 10) begin
					$display("unexpected result: tdata=%02h", m_axis_tdata);
				end
				error_count++;
			end else begin
				want = expected_flags.pop_front();
				if (m_axis_tdata[0] !== want.collision || m_axis_tdata[1] !== want.pixel ||
						m_axis_tdata[7:2] !== '0) begin
					if (error_count < 10) begin
						$display("mismatch: expected collision=%0b pixel=%0b, got tdata=%02h",
							want.collision, want.pixel, m_axis_tdata);
					end
					error_count++;
				end
			end
			gap = draw_gap(recv_burst);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				recv_gap      <= gap;
			end
		end else if (recv_gap > 1) begin
			recv_gap <= recv_gap - 1;
		end else if (recv_gap == 1) begin
			recv_gap      <= 0;
			m_axis_tready <= 1'b1;
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int pick;
		int column;
		int row;
		mode_t mode;

		foreach (shadow_rows[k]) begin
			shadow_rows[k] = '0;
		end

		// Directed: corners, wrap at both edges, collisions, set/read, clear
		add_cmd(MODE_READ, 0, 0, 8'h00);
		add_cmd(MODE_DRAW, 0, 0, 8'hFF);
		add_cmd(MODE_DRAW, 0, 0, 8'h81);
		add_cmd(MODE_READ, 7, 0, 8'hFF);
		add_cmd(MODE_READ, 6, 0, 8'h00);
		add_cmd(MODE_DRAW, 60, 31, 8'hFF);
		add_cmd(MODE_READ, 2, -1, 8'h00);
		add_cmd(MODE_DRAW, -32768, -32768, 8'hAA);
		add_cmd(MODE_DRAW, 32767, 32767, 8'h55);
		add_cmd(MODE_DRAW, -3, 5, 8'h00);
		add_cmd(MODE_SET, -1, 5, 8'hFE);
		add_cmd(MODE_SET, -1, 5, 8'h01);
		add_cmd(MODE_READ, 63, 5, 8'h00);
		add_cmd(MODE_READ, 32767, -27, 8'hAA);
		add_cmd(MODE_SET, 63, 5, 8'hFE);
		add_cmd(MODE_READ, 63, 5, 8'h00);
		add_cmd(MODE_DRAW, 62, 5, 8'hFF);
		add_cmd(MODE_DRAW, 5, 3, 8'hC3);
		add_cmd(MODE_DRAW, 5, 3, 8'hC3);
		add_cmd(MODE_READ, -32768, 32767, 8'hFF);
		add_cmd(MODE_CLEAR, 1234, -77, 8'hFF);
		add_cmd(MODE_READ, 6, 0, 8'h00);
		add_cmd(MODE_READ, -32704, 32736, 8'h00);

		// Random: mostly a small patch of the screen so draws collide and reads hit
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				mode = MODE_DRAW;
			end else if (pick < 43) begin
				mode = MODE_CLEAR;
			end else if (pick < 65) begin
				mode = MODE_SET;
			end else begin
				mode = MODE_READ;
			end
			if ($urandom_range(0, 9) < 7) begin
				row    = $urandom_range(0, 3) + 32 * (int'($urandom_range(0, 2000)) - 1000);
				column = $urandom_range(0, 63) + 64 * (int'($urandom_range(0, 1000)) - 500);
			end else begin
				row    = $urandom_range(0, 65535);
				column = $urandom_range(0, 65535);
			end
			add_cmd(mode, column, row, $urandom_range(0, 255));
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: everything sent and every prediction matched, then settle
		@(negedge clk);
		while (command_queue.size() != 0 || s_axis_tvalid || expected_flags.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_WAIT) @(negedge clk);
		if (expected_flags.size() != 0) begin
			error_count++;
		end

		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
